@@ rtl/aei_pkg.sv @@
// shared types, constants and weight-table function for the easing interpolator
package aei_pkg;

    // fixed field and datapath widths
    localparam int TW = 48;                // time width
    localparam int AW = 33;                // multiplicand magnitude width
    localparam int PW = AW + TW;           // product / dividend width
    localparam int DW = 24;                // divisor width
    localparam int CW = $clog2(PW + 1);    // step counter width

    localparam logic [DW-1:0] MS_PER_SECOND = 24'd1000;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint ONE_Q30 = 64'sd1 << 30;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_DURATION = 3'd1;
    localparam logic [2:0] CFG_START    = 3'd2;
    localparam logic [2:0] CFG_END      = 3'd3;
    localparam logic [2:0] CFG_RATE     = 3'd4;

    // mode codes
    localparam logic [2:0] MODE_CONST    = 3'd0;
    localparam logic [2:0] MODE_RAMP     = 3'd1;
    localparam logic [2:0] MODE_SLOPE    = 3'd2;
    localparam logic [2:0] MODE_EASE     = 3'd3;
    localparam logic [2:0] MODE_QUAD     = 3'd4;
    localparam logic [2:0] MODE_PERIODIC = 3'd5;

    typedef struct packed {
        logic          kind;
        logic [TW-1:0] now_ms;
    } aei_in_t;

    typedef struct packed {
        logic [31:0] value;
        logic        ended;
        logic        not_started;
    } aei_out_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_MUL,
        OP_DIV
    } md_op_t;

    typedef struct packed {
        md_op_t        op;
        logic [AW-1:0] a;
        logic [TW-1:0] b;
        logic [PW-1:0] dvd;
        logic [DW-1:0] dvs;
    } md_cmd_t;

    // raised-cosine weight (1 - cos(2*pi*k/n))/2 with f fraction bits, n = 2^lg
    function automatic logic [31:0] weight_fn(input int unsigned k, input int lg, input int f);
        longint unsigned n;
        longint unsigned m;
        longint unsigned u;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint s;
        longint c;
        longint a;
        bit neg;
        n = 64'd1 << lg;
        m = (2 * longint'(k) <= n) ? longint'(k) : n - longint'(k);
        u = 2 * m;
        neg = 1'b0;
        if (2 * u > n)
        begin
            u = n - u;
            neg = 1'b1;
        end
        x = (PI_Q30 * u) >> lg;
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        s = ONE_Q30;
        // taylor terms, divisors (2i-1)*(2i)
        t = ((t * x2) >> 30) / 64'd2;
        s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd12;
        s = s + longint'(t);
        t = ((t * x2) >> 30) / 64'd30;
        s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd56;
        s = s + longint'(t);
        t = ((t * x2) >> 30) / 64'd90;
        s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd132;
        s = s + longint'(t);
        t = ((t * x2) >> 30) / 64'd182;
        s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd240;
        s = s + longint'(t);
        if (s > ONE_Q30)
            s = ONE_Q30;
        if (s < -ONE_Q30)
            s = -ONE_Q30;
        c = neg ? -s : s;
        a = ONE_Q30 - c + (64'sd1 << (30 - f));
        weight_fn = 32'(a >>> (31 - f));
    endfunction

endpackage

@@ rtl/aei_muldiv.sv @@
// shared shift-add multiplier and restoring divider, one bit per cycle
module aei_muldiv
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  aei_pkg::md_cmd_t       cmd,
    output logic                   done,
    output logic [aei_pkg::PW-1:0] acc,
    output logic [aei_pkg::DW-1:0] rem
);
    import aei_pkg::*;

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV
    } ustate_t;

    ustate_t       st_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [PW-1:0] pr_reg;
    logic [DW-1:0] rem_reg;
    logic [AW-1:0] a_reg;
    logic [DW-1:0] dvs_reg;

    logic [AW:0]   sum;
    logic [PW-1:0] mul_next;
    logic [DW:0]   trial;
    logic [DW:0]   trial_sub;
    logic          fits;
    logic [DW-1:0] rem_next;
    logic [PW-1:0] div_next;

    // multiply step: add multiplicand on low bit, shift right
    always_comb
    begin
        sum = {1'b0, pr_reg[PW-1:TW]} + (pr_reg[0] ? {1'b0, a_reg} : '0);
        mul_next = {sum, pr_reg[TW-1:1]};
    end

    // divide step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, pr_reg[PW-1]};
        fits = (trial >= {1'b0, dvs_reg});
        trial_sub = trial - {1'b0, dvs_reg};
        rem_next = fits ? trial_sub[DW-1:0] : trial[DW-1:0];
        div_next = {pr_reg[PW-2:0], fits};
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= U_IDLE;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            unique case (st_reg) inside
                U_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (cmd.op == OP_MUL)
                    begin
                        cnt_reg <= CW'(TW);
                        st_reg <= U_MUL;
                    end
                    else if (cmd.op == OP_DIV)
                    begin
                        cnt_reg <= CW'(PW);
                        st_reg <= U_DIV;
                    end
                end
                U_MUL, U_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    done_reg <= (cnt_reg == CW'(1));
                    if (cnt_reg == CW'(1))
                    begin
                        st_reg <= U_IDLE;
                    end
                end
                default:
                begin
                    done_reg <= 1'b0;
                    st_reg <= U_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (st_reg == U_IDLE && cmd.op == OP_MUL)
        begin
            pr_reg <= {{AW{1'b0}}, cmd.b};
            a_reg <= cmd.a;
        end
        else if (st_reg == U_IDLE && cmd.op == OP_DIV)
        begin
            pr_reg <= cmd.dvd;
            rem_reg <= '0;
            dvs_reg <= cmd.dvs;
        end
        else if (st_reg == U_MUL)
        begin
            pr_reg <= mul_next;
        end
        else if (st_reg == U_DIV)
        begin
            pr_reg <= div_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign acc = pr_reg;
    assign rem = rem_reg;

endmodule

@@ rtl/aei_wrom.sv @@
// raised-cosine weight table with registered read
module aei_wrom #(
    parameter int LG   = 10,
    parameter int FRAC = 16
)
(
    input  logic          clk,
    input  logic [LG-1:0] addr,
    output logic [FRAC:0] data
);
    import aei_pkg::*;

    logic [FRAC:0] tab [2**LG];
    logic [FRAC:0] data_reg;

    // constant entries built at elaboration
    for (genvar g = 0; g < 2**LG; g++)
    begin : g_ent
        localparam logic [31:0] WV = weight_fn(g, LG, FRAC);
        assign tab[g] = WV[FRAC:0];
    end

    // registered read
    always_ff @(posedge clk)
    begin
        data_reg <= tab[addr];
    end

    assign data = data_reg;

endmodule

@@ rtl/animation_easing_interpolator.sv @@
// easing-curve interpolator top level: config, sequencer and result register
//
// Input beats on in_valid/in_ready carry kind (0 start, 1 sample) and now_ms.
// kind 0 latches now_ms as the start time; every input beat yields exactly one
// output beat on out_valid/out_ready carrying value (Q16.16), ended, not_started.
// Configuration is a plain write port: cfg_we, cfg_idx, cfg_data.
// One item is handled at a time; in_ready is high only while the sequencer idles.
// Work runs on the shared bit-serial multiply/divide unit, whose multiply pass steps
// through 48 bits and divide pass through 81. Constant, ended and not-started results
// come straight from the prep state; ramp and slope take a multiply then a divide;
// start-stop ease a divide, a table read and a multiply; periodic the same after
// a first divide; quadratic two multiply/divide passes, then idle takes the next beat.
// The result sits in an output register; a stalled receiver holds the beat and
// the next item waits in the sequencer until that register frees up.
// Reset clears configuration to its defaults (duration 1000 ms), clears the
// start time and the started flag, and leaves no beat pending.
module animation_easing_interpolator #(
    parameter int COS_TABLE_DEPTH = 1024,
    parameter int VALUE_FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_idx,
    input  logic [31:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  aei_pkg::aei_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output aei_pkg::aei_out_t out_data
);
    import aei_pkg::*;

    localparam int LG = $clog2(COS_TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_ROM,
        S_FIN,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_A_MUL,
        PH_A_DIV,
        PH_B_MUL,
        PH_B_DIV,
        PH_P_DIV,
        PH_K_DIV,
        PH_W_MUL
    } phase_t;

    // configuration
    logic [2:0]    mode_reg;
    logic [DW-1:0] dur_reg;
    logic [31:0]   start_reg;
    logic [31:0]   end_reg;
    logic [31:0]   rate_reg;

    // control and datapath
    state_t        state_reg;
    phase_t        phase_reg;
    logic          started_reg;
    logic [TW-1:0] start_time_reg;
    logic [TW-1:0] e_reg;
    logic          neg_reg;
    logic          quad_reg;
    logic [PW-1:0] mag_reg;
    aei_out_t      res_reg;
    aei_out_t      out_reg;
    logic          out_valid_reg;
    md_cmd_t       cmd_reg;

    logic          md_done;
    logic [PW-1:0] md_acc;
    logic [DW-1:0] md_rem;
    logic [VALUE_FRAC_BITS:0] rom_data;

    logic [AW-1:0] diff;
    logic [AW-1:0] abs_diff;
    logic [AW-1:0] rate_ext;
    logic [AW-1:0] abs_rate;
    logic          finite;
    logic          reached;
    logic [31:0]   fin_value;

    // saturating start +/- magnitude
    function automatic logic [31:0] sat_sum(input logic [31:0] base, input logic [PW-1:0] mag,
                                            input logic neg);
        logic [34:0] b;
        logic [34:0] m;
        logic [34:0] s;
        b = {{3{base[31]}}, base};
        m = {2'b00, mag[AW-1:0]};
        s = neg ? b - m : b + m;
        if (|mag[PW-1:AW])
            sat_sum = neg ? 32'h8000_0000 : 32'h7fff_ffff;
        else if (s[34:31] != {4{s[34]}})
            sat_sum = s[34] ? 32'h8000_0000 : 32'h7fff_ffff;
        else
            sat_sum = s[31:0];
    endfunction

    // shared multiply/divide unit
    aei_muldiv u_md
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_reg),
        .done  (md_done),
        .acc   (md_acc),
        .rem   (md_rem)
    );

    // weight table addressed by the last quotient
    aei_wrom #(
        .LG   (LG),
        .FRAC (VALUE_FRAC_BITS)
    ) u_rom
    (
        .clk  (clk),
        .addr (md_acc[LG-1:0]),
        .data (rom_data)
    );

    // operand magnitudes and end test
    always_comb
    begin
        diff = {end_reg[31], end_reg} - {start_reg[31], start_reg};
        abs_diff = diff[AW-1] ? -diff : diff;
        rate_ext = {rate_reg[31], rate_reg};
        abs_rate = rate_ext[AW-1] ? -rate_ext : rate_ext;
        finite = (mode_reg == MODE_RAMP) || (mode_reg == MODE_EASE) || (mode_reg == MODE_QUAD);
        reached = (e_reg >= {{(TW-DW){1'b0}}, dur_reg});
        fin_value = sat_sum(start_reg, mag_reg, neg_reg);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CONST;
            dur_reg <= 24'd1000;
            start_reg <= '0;
            end_reg <= '0;
            rate_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_MODE:     mode_reg <= cfg_data[2:0];
                CFG_DURATION: dur_reg <= cfg_data[DW-1:0];
                CFG_START:    start_reg <= cfg_data;
                CFG_END:      end_reg <= cfg_data;
                CFG_RATE:     rate_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_A_MUL;
            started_reg <= 1'b0;
            start_time_reg <= '0;
            e_reg <= '0;
            neg_reg <= 1'b0;
            quad_reg <= 1'b0;
            mag_reg <= '0;
            res_reg <= '0;
            out_reg <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg <= '0;
        end
        else
        begin
            // output beat register: load on a free slot, drop on acceptance
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (!in_data.kind)
                        begin
                            start_time_reg <= in_data.now_ms;
                            started_reg <= 1'b1;
                            e_reg <= '0;
                        end
                        else
                        begin
                            e_reg <= (in_data.now_ms >= start_time_reg) ?
                                     in_data.now_ms - start_time_reg : '0;
                        end
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    neg_reg <= (mode_reg == MODE_SLOPE) ? rate_reg[31] : diff[AW-1];
                    quad_reg <= (mode_reg == MODE_QUAD);
                    cmd_reg.dvs <= (mode_reg == MODE_SLOPE) ? MS_PER_SECOND : dur_reg;
                    if (!started_reg)
                    begin
                        res_reg <= '{value: '0, ended: 1'b0, not_started: 1'b1};
                        state_reg <= S_DONE;
                    end
                    else if (finite && reached)
                    begin
                        res_reg <= '{value: end_reg, ended: 1'b1, not_started: 1'b0};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        case (mode_reg) inside
                            MODE_CONST:
                            begin
                                res_reg <= '{value: end_reg, ended: 1'b0, not_started: 1'b0};
                                state_reg <= S_DONE;
                            end
                            MODE_RAMP, MODE_QUAD:
                            begin
                                cmd_reg.op <= OP_MUL;
                                cmd_reg.a <= abs_diff;
                                cmd_reg.b <= e_reg;
                                phase_reg <= PH_A_MUL;
                                state_reg <= S_RUN;
                            end
                            MODE_SLOPE:
                            begin
                                cmd_reg.op <= OP_MUL;
                                cmd_reg.a <= abs_rate;
                                cmd_reg.b <= e_reg;
                                phase_reg <= PH_A_MUL;
                                state_reg <= S_RUN;
                            end
                            MODE_EASE:
                            begin
                                cmd_reg.op <= OP_DIV;
                                cmd_reg.dvd <= PW'(e_reg) << (LG - 1);
                                phase_reg <= PH_K_DIV;
                                state_reg <= S_RUN;
                            end
                            MODE_PERIODIC:
                            begin
                                if (dur_reg != '0)
                                begin
                                    cmd_reg.op <= OP_DIV;
                                    cmd_reg.dvd <= PW'(e_reg);
                                    phase_reg <= PH_P_DIV;
                                    state_reg <= S_RUN;
                                end
                                else
                                begin
                                    res_reg <= '{value: start_reg, ended: 1'b0,
                                                 not_started: 1'b0};
                                    state_reg <= S_DONE;
                                end
                            end
                            default:
                            begin
                                res_reg <= '{value: start_reg, ended: 1'b0, not_started: 1'b0};
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RUN:
                begin
                    if (md_done)
                    begin
                        unique case (phase_reg) inside
                            PH_A_MUL, PH_B_MUL:
                            begin
                                cmd_reg.op <= OP_DIV;
                                cmd_reg.dvd <= md_acc;
                                phase_reg <= (phase_reg == PH_A_MUL) ? PH_A_DIV : PH_B_DIV;
                            end
                            PH_A_DIV:
                            begin
                                if (quad_reg)
                                begin
                                    cmd_reg.op <= OP_MUL;
                                    cmd_reg.a <= md_acc[AW-1:0];
                                    cmd_reg.b <= e_reg;
                                    phase_reg <= PH_B_MUL;
                                end
                                else
                                begin
                                    mag_reg <= md_acc;
                                    state_reg <= S_FIN;
                                end
                            end
                            PH_B_DIV:
                            begin
                                mag_reg <= md_acc;
                                state_reg <= S_FIN;
                            end
                            PH_P_DIV:
                            begin
                                cmd_reg.op <= OP_DIV;
                                cmd_reg.dvd <= PW'(md_rem) << LG;
                                phase_reg <= PH_K_DIV;
                            end
                            PH_K_DIV:
                            begin
                                state_reg <= S_ROM;
                            end
                            PH_W_MUL:
                            begin
                                mag_reg <= md_acc >> VALUE_FRAC_BITS;
                                state_reg <= S_FIN;
                            end
                            default:
                            begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                    else
                    begin
                        // command is a one-cycle pulse
                        cmd_reg.op <= OP_NONE;
                    end
                end
                S_ROM:
                begin
                    cmd_reg.op <= OP_MUL;
                    cmd_reg.a <= abs_diff;
                    cmd_reg.b <= TW'(rom_data);
                    phase_reg <= PH_W_MUL;
                    state_reg <= S_RUN;
                end
                S_FIN:
                begin
                    res_reg <= '{value: fin_value, ended: 1'b0, not_started: 1'b0};
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

`ifndef SYNTHESIS
    // an accepted beat makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // not-started result carries a zero value and no ended flag
    a_not_started_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.not_started |-> out_data.value == '0 && !out_data.ended)
        else $error("not-started beat carries data");

    // only finite modes raise ended
    a_ended_finite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.ended |->
        mode_reg == MODE_RAMP || mode_reg == MODE_EASE || mode_reg == MODE_QUAD)
        else $error("ended raised in a non-finite mode");
`endif

endmodule
